// File: rtl/fpsc_pkg.sv
// Shared constants and types for the Fitch parsimony site combiner.
package fpsc_pkg;

	// Number of per-site mutation counters and the address width that follows from it.
	localparam int unsigned MAX_SITES = 4096;
	localparam int unsigned ADDR_W    = (MAX_SITES > 1) ? $clog2(MAX_SITES) : 1;

	// Field widths.
	localparam int unsigned SET_W    = 8;
	localparam int unsigned WEIGHT_W = 32;
	localparam int unsigned CNT_W    = 8;
	localparam int unsigned COST_W   = 48;

	// Output queue geometry.
	localparam int unsigned OUT_DEPTH = 4;
	localparam int unsigned PTR_W     = $clog2(OUT_DEPTH);
	localparam int unsigned LVL_W     = PTR_W + 1;

	localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(MAX_SITES - 1);
	localparam logic [COST_W-1:0] COST_MAX  = '1;

	// Configuration register indexes.
	localparam int unsigned     CFG_IDX_W           = 1;
	localparam logic [CFG_IDX_W-1:0] REG_USE_WEIGHTS     = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_COUNT_MUTATIONS = 1'd1;

	// Read-modify-write update of one mutation counter.
	typedef struct packed {
		logic              valid;
		logic              inc;
		logic [ADDR_W-1:0] addr;
	} upd_t;

	// One result as it waits in the output queue.
	typedef struct packed {
		logic [SET_W-1:0]  combined_set;
		logic              is_change;
		logic [CNT_W-1:0]  site_mutations;
		logic [COST_W-1:0] total_cost;
		logic              is_last;
	} res_t;

endpackage

// File: rtl/fpsc_count_store.sv
// Per-site mutation counter memory with clearing pass and write forwarding.
module fpsc_count_store (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        rd_en,
	input  logic [fpsc_pkg::ADDR_W-1:0] rd_addr,
	input  fpsc_pkg::upd_t              upd,
	output logic [fpsc_pkg::CNT_W-1:0]  count,
	output logic                        busy
);

	logic [fpsc_pkg::CNT_W-1:0]  mem [fpsc_pkg::MAX_SITES];
	logic [fpsc_pkg::CNT_W-1:0]  rd_data_q;
	logic [fpsc_pkg::CNT_W-1:0]  fwd_data_q;
	logic                        fwd_hit_q;
	logic                        clr_active_q;
	logic [fpsc_pkg::ADDR_W-1:0] clr_addr_q;
	logic [fpsc_pkg::CNT_W-1:0]  base;
	logic                        wr_en;
	logic [fpsc_pkg::ADDR_W-1:0] wr_addr;
	logic [fpsc_pkg::CNT_W-1:0]  wr_data;
	logic                        upd_write;

	// The stored count, or the value written in the same cycle the read was issued.
	assign base      = fwd_hit_q ? fwd_data_q : rd_data_q;
	assign count     = base + fpsc_pkg::CNT_W'(upd.inc);
	assign upd_write = upd.valid && upd.inc;

	// The clearing pass owns the write port until it finishes.
	assign wr_en   = clr_active_q || upd_write;
	assign wr_addr = clr_active_q ? clr_addr_q : upd.addr;
	assign wr_data = clr_active_q ? '0 : count;
	assign busy    = clr_active_q;

	// Memory array: one write and one registered read each cycle.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	// The forwarded value only matters when the hit flag is set.
	always_ff @(posedge clk) begin
		fwd_data_q <= count;
	end

	// Clearing pass after reset and detection of a read that races a write.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_active_q <= 1'b1;
			clr_addr_q   <= '0;
			fwd_hit_q    <= 1'b0;
		end else begin
			if (clr_active_q) begin
				if (clr_addr_q == fpsc_pkg::LAST_ADDR) begin
					clr_active_q <= 1'b0;
				end
				clr_addr_q <= clr_addr_q + 1'b1;
			end
			fwd_hit_q <= rd_en && upd_write && (upd.addr == rd_addr);
		end
	end

endmodule

// File: rtl/fpsc_out_fifo.sv
// Small output queue that decouples the result side from the site pipeline.
module fpsc_out_fifo (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       push,
	input  fpsc_pkg::res_t             push_data,
	input  logic                       pop_ready,
	output logic                       pop_valid,
	output fpsc_pkg::res_t             pop_data,
	output logic [fpsc_pkg::LVL_W-1:0] level
);

	fpsc_pkg::res_t              entry_q [fpsc_pkg::OUT_DEPTH];
	logic [fpsc_pkg::PTR_W-1:0] wr_ptr_q;
	logic [fpsc_pkg::PTR_W-1:0] rd_ptr_q;
	logic [fpsc_pkg::LVL_W-1:0] level_q;
	logic                       pop;

	assign pop_valid = (level_q != '0);
	assign pop_data  = entry_q[rd_ptr_q];
	assign pop       = pop_valid && pop_ready;
	assign level     = level_q;

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	// Pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			level_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				level_q <= level_q + 1'b1;
			end else if (pop && !push) begin
				level_q <= level_q - 1'b1;
			end
		end
	end

endmodule

// File: rtl/fitch_parsimony_site_combine.sv
// Fitch parsimony site combiner: accepted sites pass stage one, then the output queue.
// One site per cycle while in_ready is high; the counter memory does one read and one
// write per cycle. A site's counter read is issued at accept and the update is written
// back in the following cycle. After reset the 4096-entry counter memory is cleared one
// entry per cycle; in_ready stays low while clearing, but configuration writes are taken.
module fitch_parsimony_site_combine (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [fpsc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic                           cfg_data,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [fpsc_pkg::SET_W-1:0]     left_set,
	input  logic [fpsc_pkg::SET_W-1:0]     right_set,
	input  logic [fpsc_pkg::WEIGHT_W-1:0]  site_weight,
	input  logic                           last_site,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [fpsc_pkg::SET_W-1:0]     combined_set,
	output logic                           is_change,
	output logic [fpsc_pkg::CNT_W-1:0]     site_mutations,
	output logic [fpsc_pkg::COST_W-1:0]    total_cost,
	output logic                           is_last
);

	logic                          use_weights_q;
	logic                          count_mutations_q;
	logic [fpsc_pkg::ADDR_W-1:0]   pos_q;
	logic [fpsc_pkg::COST_W-1:0]   cost_q;

	logic                          in_fire;
	logic                          busy;
	logic [fpsc_pkg::SET_W-1:0]    both;
	logic                          change;
	logic [fpsc_pkg::SET_W-1:0]    combined;
	logic [fpsc_pkg::WEIGHT_W-1:0] addend;
	logic [fpsc_pkg::COST_W:0]     sum;
	logic [fpsc_pkg::COST_W-1:0]   sat_sum;
	logic [fpsc_pkg::COST_W-1:0]   total;

	logic                          valid_s1;
	logic [fpsc_pkg::SET_W-1:0]    combined_s1;
	logic                          change_s1;
	logic                          inc_s1;
	logic [fpsc_pkg::COST_W-1:0]   total_s1;
	logic                          last_s1;
	logic [fpsc_pkg::ADDR_W-1:0]   addr_s1;

	fpsc_pkg::upd_t                upd;
	logic [fpsc_pkg::CNT_W-1:0]    count;
	fpsc_pkg::res_t                push_data;
	fpsc_pkg::res_t                pop_data;
	logic [fpsc_pkg::LVL_W-1:0]    level;
	logic [fpsc_pkg::LVL_W:0]      in_flight;

	// Accept when not clearing and the queue has room for every site in flight plus this one.
	assign in_flight = {1'b0, level} + (fpsc_pkg::LVL_W + 1)'(valid_s1);
	assign in_ready  = !busy && (in_flight < (fpsc_pkg::LVL_W + 1)'(fpsc_pkg::OUT_DEPTH));
	assign in_fire   = in_valid && in_ready;

	// Set intersection, falling back to the union when it is empty.
	assign both     = left_set & right_set;
	assign change   = (both == '0);
	assign combined = change ? (left_set | right_set) : both;

	// Saturating cost accumulation.
	assign addend  = use_weights_q ? site_weight : fpsc_pkg::WEIGHT_W'(1);
	assign sum     = {1'b0, cost_q} + (fpsc_pkg::COST_W + 1)'(addend);
	assign sat_sum = sum[fpsc_pkg::COST_W] ? fpsc_pkg::COST_MAX : sum[fpsc_pkg::COST_W-1:0];
	assign total   = change ? sat_sum : cost_q;

	// Configuration registers; unknown indexes cannot occur with a one-bit index.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			use_weights_q     <= 1'b0;
			count_mutations_q <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				fpsc_pkg::REG_USE_WEIGHTS:     use_weights_q     <= cfg_data;
				fpsc_pkg::REG_COUNT_MUTATIONS: count_mutations_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Site position and running cost, restarted after the last site.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= '0;
			cost_q <= '0;
		end else if (in_fire) begin
			if (last_site) begin
				pos_q  <= '0;
				cost_q <= '0;
			end else begin
				pos_q  <= (pos_q == fpsc_pkg::LAST_ADDR) ? '0 : pos_q + 1'b1;
				cost_q <= total;
			end
		end
	end

	// Stage one valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= in_fire;
		end
	end

	// Stage one payload, held while the counter read is in progress.
	always_ff @(posedge clk) begin
		if (in_fire) begin
			combined_s1 <= combined;
			change_s1   <= change;
			inc_s1      <= change && count_mutations_q;
			total_s1    <= total;
			last_s1     <= last_site;
			addr_s1     <= pos_q;
		end
	end

	// Counter update for the site in stage one.
	assign upd.valid = valid_s1;
	assign upd.inc   = inc_s1;
	assign upd.addr  = addr_s1;

	fpsc_count_store u_count_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (in_fire),
		.rd_addr (pos_q),
		.upd     (upd),
		.count   (count),
		.busy    (busy)
	);

	// Finished result into the output queue.
	assign push_data.combined_set   = combined_s1;
	assign push_data.is_change      = change_s1;
	assign push_data.site_mutations = count;
	assign push_data.total_cost     = total_s1;
	assign push_data.is_last        = last_s1;

	fpsc_out_fifo u_out_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (valid_s1),
		.push_data (push_data),
		.pop_ready (out_ready),
		.pop_valid (out_valid),
		.pop_data  (pop_data),
		.level     (level)
	);

	assign combined_set   = pop_data.combined_set;
	assign is_change      = pop_data.is_change;
	assign site_mutations = pop_data.site_mutations;
	assign total_cost     = pop_data.total_cost;
	assign is_last        = pop_data.is_last;

endmodule
